// ===== rtl/core/irc_pkg.sv =====
`timescale 1ns / 1ps

package irc_pkg;

  // Position datapath: (2k+1)*src is 19 bits, scaled by 2^15 for the Q16 step.
  localparam int PROD_W    = 19;
  localparam int NUM_W     = 34;
  localparam int DIV_STEPS = NUM_W;
  localparam int FRAC_W    = 16;
  localparam int AXIS_LAT  = DIV_STEPS + 2;
  localparam int BLEND_LAT = 5;

  typedef enum logic [2:0] {
    CFG_SRC_WIDTH   = 3'd0,
    CFG_SRC_HEIGHT  = 3'd1,
    CFG_DST_WIDTH   = 3'd2,
    CFG_DST_HEIGHT  = 3'd3,
    CFG_INTERP_MODE = 3'd4
  } irc_cfg_idx_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } irc_req_t;

  typedef enum logic {
    MODE_NEAREST  = 1'b0,
    MODE_BILINEAR = 1'b1
  } irc_mode_t;

  typedef struct packed {
    logic [7:0]        idx;
    logic              same;
    logic [FRAC_W-1:0] frac;
  } irc_pos_t;

  typedef struct packed {
    logic       req;
    logic       oor;
    logic [1:0] ch;
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] pix;
  } irc_side_t;

endpackage

// ===== rtl/core/image_resize_interpolator_core.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while no held result stalls the pipeline;
// two 34-stage restoring dividers set the depth.
// The source store is four parity banks, so all four neighbors are read in the same cycle.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default sizes
// and bilinear mode; pixel storage is not cleared.
module image_resize_interpolator_core
  import irc_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 128,
  parameter int MAX_SRC_HEIGHT = 128,
  parameter int MAX_CHANNELS   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [9:0]  in_col,
  input  logic [9:0]  in_row,
  input  logic [1:0]  in_channel,
  input  logic [7:0]  in_pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_out,
  output logic        out_out_of_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int XB  = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int YB  = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
  localparam int XHB = (XB > 1) ? XB - 1 : 1;
  localparam int YHB = (YB > 1) ? YB - 1 : 1;
  localparam int CB  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AW  = CB + YHB + XHB;
  localparam int BANK_DEPTH = 1 << AW;

  logic [7:0]  src_width_r, src_height_r;
  logic [10:0] dst_width_r, dst_height_r;
  logic        interp_mode_r;
  logic [7:0]  sw, sh;
  logic [10:0] dw, dh;

  logic        adv;
  logic        s0_valid_r;
  irc_side_t   s0_r, s0_nxt;
  logic        side_v_r [AXIS_LAT];
  irc_side_t   side_r   [AXIS_LAT];
  irc_pos_t    pos_x, pos_y;

  logic        m_valid_r;
  irc_side_t   m_side_r;
  irc_pos_t    m_px_r, m_py_r;
  logic [AW-1:0] raddr [4];
  logic [AW-1:0] waddr;
  logic [3:0]    we;
  logic [7:0]    rdata [4];
  logic [7:0]    p00, p10, p01, p11;
  logic [7:0]    blend_pix;

  logic        bl_v_r [BLEND_LAT];
  irc_side_t   bl_r   [BLEND_LAT];

  logic        out_valid_r;
  logic [7:0]  out_pixel_out_r;
  logic        out_out_of_range_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r   <= 8'd128;
      src_height_r  <= 8'd128;
      dst_width_r   <= 11'd128;
      dst_height_r  <= 11'd128;
      interp_mode_r <= MODE_BILINEAR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (irc_cfg_idx_t'(cfg_index))
        CFG_SRC_WIDTH:   src_width_r   <= cfg_data[7:0];
        CFG_SRC_HEIGHT:  src_height_r  <= cfg_data[7:0];
        CFG_DST_WIDTH:   dst_width_r   <= cfg_data;
        CFG_DST_HEIGHT:  dst_height_r  <= cfg_data;
        CFG_INTERP_MODE: interp_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sw = src_width_r;
    if (src_width_r == 8'd0) begin
      sw = 8'd1;
    end else if (32'(src_width_r) > MAX_SRC_WIDTH) begin
      sw = 8'(MAX_SRC_WIDTH);
    end
    sh = src_height_r;
    if (src_height_r == 8'd0) begin
      sh = 8'd1;
    end else if (32'(src_height_r) > MAX_SRC_HEIGHT) begin
      sh = 8'(MAX_SRC_HEIGHT);
    end
    dw = (dst_width_r == 11'd0) ? 11'd1 : dst_width_r;
    dh = (dst_height_r == 11'd0) ? 11'd1 : dst_height_r;
  end

  // the whole pipeline moves as one; only a held result stops it
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_comb begin
    s0_nxt.req = in_req_type;
    s0_nxt.ch  = in_channel;
    s0_nxt.col = in_col;
    s0_nxt.row = in_row;
    s0_nxt.pix = in_pixel_in;
    if (in_req_type == REQ_WRITE) begin
      s0_nxt.oor = (in_col >= 10'(sw)) || (in_row >= 10'(sh))
                || (32'(in_channel) >= MAX_CHANNELS);
    end else begin
      s0_nxt.oor = ({1'b0, in_col} >= dw) || ({1'b0, in_row} >= dh)
                || (32'(in_channel) >= MAX_CHANNELS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= s0_nxt;
    end
  end

  irc_axis u_axis_x (
    .clk (clk),
    .en  (adv),
    .k   (s0_r.col),
    .src (sw),
    .dst (dw),
    .mode(interp_mode_r),
    .pos (pos_x)
  );

  irc_axis u_axis_y (
    .clk (clk),
    .en  (adv),
    .k   (s0_r.row),
    .src (sh),
    .dst (dh),
    .mode(interp_mode_r),
    .pos (pos_y)
  );

  // carry the transaction alongside the position dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXIS_LAT; i++) begin
        side_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      side_v_r[0] <= s0_valid_r;
      for (int i = 1; i < AXIS_LAT; i++) begin
        side_v_r[i] <= side_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= s0_r;
      for (int i = 1; i < AXIS_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // bank {y[0], x[0]}; the even bank of a pair takes the rounded-up half index
  always_comb begin
    logic [XHB-1:0] xodd, xeven;
    logic [YHB-1:0] yodd, yeven;
    logic [CB-1:0]  chb;
    logic [1:0]     wbank;
    xodd  = XHB'(pos_x.idx >> 1);
    xeven = XHB'((9'(pos_x.idx) + 9'(pos_x.idx[0])) >> 1);
    yodd  = YHB'(pos_y.idx >> 1);
    yeven = YHB'((9'(pos_y.idx) + 9'(pos_y.idx[0])) >> 1);
    chb   = CB'(side_r[AXIS_LAT-1].ch);
    for (int b = 0; b < 4; b++) begin
      raddr[b] = {chb, (b[1] ? yodd : yeven), (b[0] ? xodd : xeven)};
    end
    waddr = {chb, YHB'(side_r[AXIS_LAT-1].row >> 1), XHB'(side_r[AXIS_LAT-1].col >> 1)};
    wbank = {side_r[AXIS_LAT-1].row[0], side_r[AXIS_LAT-1].col[0]};
    for (int b = 0; b < 4; b++) begin
      we[b] = adv && side_v_r[AXIS_LAT-1] && (side_r[AXIS_LAT-1].req == REQ_WRITE)
           && !side_r[AXIS_LAT-1].oor && (wbank == 2'(b));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    irc_ram #(
      .WIDTH(8),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (we[b]),
      .waddr(waddr),
      .wdata(side_r[AXIS_LAT-1].pix),
      .re   (adv),
      .raddr(raddr[b]),
      .rdata(rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r <= side_v_r[AXIS_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_side_r <= side_r[AXIS_LAT-1];
      m_px_r   <= pos_x;
      m_py_r   <= pos_y;
    end
  end

  // pick neighbors out of the banks; a clamped edge reuses the near sample
  always_comb begin
    p00 = rdata[{m_py_r.idx[0], m_px_r.idx[0]}];
    p10 = m_px_r.same ? p00 : rdata[{m_py_r.idx[0], ~m_px_r.idx[0]}];
    p01 = m_py_r.same ? p00 : rdata[{~m_py_r.idx[0], m_px_r.idx[0]}];
    if (m_px_r.same) begin
      p11 = p01;
    end else if (m_py_r.same) begin
      p11 = p10;
    end else begin
      p11 = rdata[{~m_py_r.idx[0], ~m_px_r.idx[0]}];
    end
  end

  irc_blend u_blend (
    .clk(clk),
    .en (adv),
    .a  (p00),
    .b  (p10),
    .c  (p01),
    .d  (p11),
    .fx (m_px_r.frac),
    .fy (m_py_r.frac),
    .pix(blend_pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BLEND_LAT; i++) begin
        bl_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      bl_v_r[0] <= m_valid_r;
      for (int i = 1; i < BLEND_LAT; i++) begin
        bl_v_r[i] <= bl_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bl_r[0] <= m_side_r;
      for (int i = 1; i < BLEND_LAT; i++) begin
        bl_r[i] <= bl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= bl_v_r[BLEND_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_out_of_range_r <= bl_r[BLEND_LAT-1].oor;
      out_pixel_out_r    <= ((bl_r[BLEND_LAT-1].req == REQ_READ) && !bl_r[BLEND_LAT-1].oor)
                          ? blend_pix : 8'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pixel_out_r;
  assign out_out_of_range = out_out_of_range_r;

endmodule

// ===== rtl/core/irc_ram.sv =====
`timescale 1ns / 1ps

module irc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/irc_axis.sv =====
`timescale 1ns / 1ps

module irc_axis
  import irc_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [9:0] k,
  input  logic [7:0] src,
  input  logic [10:0] dst,
  input  logic       mode,
  output irc_pos_t   pos
);

  logic [PROD_W-1:0] prod_r;
  logic [10:0]       rem_r [DIV_STEPS];
  logic [NUM_W-1:0]  quo_r [DIV_STEPS];
  logic [NUM_W-1:0]  num_r [DIV_STEPS];
  irc_pos_t          pos_r;
  irc_pos_t          pos_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'({k, 1'b1}) * PROD_W'(src);
    end
  end

  // Restoring divide of (2k+1)*src*2^15 by dst, one quotient bit per stage.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [10:0]      rem_in;
    logic [NUM_W-1:0] quo_in;
    logic [NUM_W-1:0] num_in;
    logic [11:0]      trial;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = {prod_r, (NUM_W - PROD_W)'(0)};
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
      assign num_in = num_r[j-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, dst}) begin
          rem_r[j] <= 11'(trial - {1'b0, dst});
          quo_r[j] <= {quo_in[NUM_W-2:0], 1'b1};
        end else begin
          rem_r[j] <= trial[10:0];
          quo_r[j] <= {quo_in[NUM_W-2:0], 1'b0};
        end
        num_r[j] <= {num_in[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [NUM_W-1:0] q;
    logic [NUM_W-1:0] p;
    logic [7:0]       sm1;
    q   = quo_r[DIV_STEPS-1];
    p   = q - NUM_W'(32768);
    sm1 = src - 8'd1;
    pos_nxt.idx  = '0;
    pos_nxt.same = 1'b1;
    pos_nxt.frac = '0;
    if (mode == MODE_NEAREST) begin
      if (q[NUM_W-1:FRAC_W] > 18'(sm1)) begin
        pos_nxt.idx = sm1;
      end else begin
        pos_nxt.idx = q[FRAC_W+7:FRAC_W];
      end
    end else if (q >= NUM_W'(32768)) begin
      // positions left of the first sample skip this branch and stay clamped to index zero
      pos_nxt.frac = p[FRAC_W-1:0];
      if (p[NUM_W-1:FRAC_W] >= 18'(sm1)) begin
        pos_nxt.idx = sm1;
      end else begin
        pos_nxt.idx  = p[FRAC_W+7:FRAC_W];
        pos_nxt.same = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

endmodule

// ===== rtl/core/irc_blend.sv =====
`timescale 1ns / 1ps

module irc_blend
  import irc_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [7:0]        a,
  input  logic [7:0]        b,
  input  logic [7:0]        c,
  input  logic [7:0]        d,
  input  logic [FRAC_W-1:0] fx,
  input  logic [FRAC_W-1:0] fy,
  output logic [7:0]        pix
);

  logic [7:0]         a1_r, c1_r;
  logic signed [25:0] m0_r, m1_r;
  logic [FRAC_W-1:0]  fy1_r, fy2_r, fy3_r;
  logic signed [25:0] t0_r, t1_r, t0_3_r, dt_r, t0_4_r;
  logic signed [42:0] prod_r;
  logic [7:0]         pix_r;
  logic signed [42:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      // horizontal weights: t = a*2^16 + (b-a)*fx
      a1_r  <= a;
      c1_r  <= c;
      m0_r  <= 26'($signed(9'({1'b0, b}) - 9'({1'b0, a})) * $signed({1'b0, fx}));
      m1_r  <= 26'($signed(9'({1'b0, d}) - 9'({1'b0, c})) * $signed({1'b0, fx}));
      fy1_r <= fy;

      t0_r  <= $signed({2'b00, a1_r, 16'b0}) + m0_r;
      t1_r  <= $signed({2'b00, c1_r, 16'b0}) + m1_r;
      fy2_r <= fy1_r;

      dt_r   <= t1_r - t0_r;
      t0_3_r <= t0_r;
      fy3_r  <= fy2_r;

      prod_r <= 43'(dt_r * $signed({1'b0, fy3_r}));
      t0_4_r <= t0_3_r;

      pix_r <= sum[39:32];
    end
  end

  // round half up from Q32
  assign sum = (43'(t0_4_r) <<< 16) + prod_r + (43'(1) <<< 31);
  assign pix = pix_r;

endmodule

// ===== rtl/core/irc_checker.sv =====
`timescale 1ns / 1ps

module irc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pixel_out,
  input logic       out_out_of_range
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out)
                               && $stable(out_out_of_range))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while a result is held");

  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_pixel_out == 8'd0)
    else $error("out of range result carries a pixel");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind image_resize_interpolator_core irc_checker u_irc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel_out   (out_pixel_out),
  .out_out_of_range(out_out_of_range)
);
